// ===== hw/rtl/asg_pkg.sv =====
// shared types and constants for the allreduce schedule generator
`timescale 1ns / 1ps
`default_nettype none
package asg_pkg;

	localparam int MAX_RANKS = 1024;
	localparam int RANK_W    = $clog2(MAX_RANKS);
	localparam int SIZE_W    = RANK_W + 1;
	localparam int TAG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MY_RANK    = 2'd1;

	typedef enum logic [2:0] {
		OP_SEND     = 3'd0,
		OP_RECV     = 3'd1,
		OP_SENDRECV = 3'd2,
		OP_REDUCE   = 3'd3,
		OP_RELEASE  = 3'd4,
		OP_COMPLETE = 3'd5
	} op_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG,
		ST_EXTRA,
		ST_FOLD,
		ST_PRE1,
		ST_PRE2,
		ST_ROUND_SR,
		ST_ROUND_RED,
		ST_POST,
		ST_REL,
		ST_ONE
	} asg_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/allreduce_schedule_generator_unit.sv =====
// top level of the allreduce schedule generator: sequencer and output register
//
// usage:
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets group_size
//   (index 0) and my_rank (index 1); write only while the block is idle.
//   an input item (request_tag, long_buffer) is taken when in_valid and
//   in_ready are high; it yields the ordered list of operations for a
//   recursive-doubling allreduce, one output item per operation, with last
//   set on the final one.
// sequencing:
//   a group of one goes to ST_ONE and loads its single item into the output register.
//   otherwise the sequencer finds lg = floor(log2(size)) in ST_LOG with the
//   shift/compare, forms the fold split and new rank in ST_EXTRA and ST_FOLD,
//   then emits one operation per state (2*lg+4 at most); in_ready stays low
//   until the last operation has been loaded into the output register.
// reset: arst_n clears the sequencer and output valid, and sets group_size
//   to one and my_rank to zero.
// stall: the output register holds while out_ready is low and the sequencer
//   waits on it; no operation is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module allreduce_schedule_generator_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [asg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [asg_pkg::SIZE_W-1:0]     cfg_data,
	// request channel
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [asg_pkg::TAG_W-1:0]      request_tag,
	input  wire                            long_buffer,
	// operation channel
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [2:0]                     op_kind,
	output logic [asg_pkg::RANK_W-1:0]     peer,
	output logic                           from_receive,
	output logic                           into_receive,
	output logic [asg_pkg::TAG_W-1:0]      tag_out,
	output logic                           long_out,
	output logic                           last
);
	import asg_pkg::*;

	// configuration registers
	logic [SIZE_W-1:0] group_size_q;
	logic [RANK_W-1:0] my_rank_q;

	// per-request working registers
	asg_state_t        state_q, state_d;
	logic [SIZE_W-1:0] size_q;
	logic [RANK_W-1:0] rank_q;
	logic [TAG_W-1:0]  tag_q;
	logic              long_q;
	logic [SIZE_W-1:0] adj_q;
	logic [SIZE_W-1:0] dist_q;
	logic [RANK_W-1:0] extra_q;
	logic [RANK_W-1:0] newrank_q;
	logic              folded_q;

	// output register
	logic              out_valid_q;
	op_kind_t          kind_q;
	logic [RANK_W-1:0] peer_q;
	logic              from_q;
	logic              into_q;
	logic              last_q;

	logic              in_acc;
	logic              slot_free;
	logic [SIZE_W-1:0] size_sat;
	logic [SIZE_W:0]   adj_dbl;
	logic [SIZE_W-1:0] dist_dbl;
	logic              fold_now;
	logic [RANK_W-1:0] nr;
	logic [RANK_W-1:0] remote;

	// emitted operation for the current state
	logic              emit;
	op_kind_t          e_kind;
	logic [RANK_W-1:0] e_peer;
	logic              e_from;
	logic              e_into;
	logic              e_last;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// groups larger than the rank space saturate
	assign size_sat = (group_size_q > SIZE_W'(MAX_RANKS)) ? SIZE_W'(MAX_RANKS) : group_size_q;

	// shifts for the log search (adj doubled) and the round distance (dist doubled)
	assign adj_dbl  = {adj_q, 1'b0};
	assign dist_dbl = {dist_q[SIZE_W-2:0], 1'b0};

	// a rank in the first 2*extra pairs up with its neighbor
	assign fold_now = {1'b0, rank_q} < {extra_q, 1'b0};

	// round peer: partner new rank, mapped back to a real rank
	assign nr     = newrank_q ^ dist_q[RANK_W-1:0];
	assign remote = (nr < extra_q) ? {nr[RANK_W-2:0], 1'b1} : RANK_W'(nr + extra_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= SIZE_W'(1);
			my_rank_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_GROUP_SIZE)
				group_size_q <= cfg_data;
			else if (cfg_index == REG_MY_RANK)
				my_rank_q <= cfg_data[RANK_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = (size_sat <= SIZE_W'(1)) ? ST_ONE : ST_LOG;
			end
			ST_LOG: begin
				if (adj_dbl > {1'b0, size_q})
					state_d = ST_EXTRA;
			end
			ST_EXTRA: state_d = ST_FOLD;
			ST_FOLD:  state_d = fold_now ? ST_PRE1 : ST_ROUND_SR;
			ST_PRE1: begin
				if (slot_free)
					state_d = rank_q[0] ? ST_PRE2 : ST_POST;
			end
			ST_PRE2: begin
				if (slot_free)
					state_d = ST_ROUND_SR;
			end
			ST_ROUND_SR: begin
				if (slot_free)
					state_d = ST_ROUND_RED;
			end
			ST_ROUND_RED: begin
				if (slot_free) begin
					if (dist_dbl < adj_q)
						state_d = ST_ROUND_SR;
					else
						state_d = folded_q ? ST_POST : ST_REL;
				end
			end
			ST_POST: begin
				if (slot_free)
					state_d = ST_REL;
			end
			ST_REL, ST_ONE: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operation produced in each state
	always_comb begin
		emit   = 1'b0;
		e_kind = OP_RELEASE;
		e_peer = '0;
		e_from = 1'b0;
		e_into = 1'b0;
		e_last = 1'b0;
		unique case (state_q)
			ST_PRE1: begin
				emit = 1'b1;
				if (rank_q[0]) begin
					e_kind = OP_RECV;
					e_peer = rank_q - RANK_W'(1);
					e_from = 1'b1;
					e_into = 1'b1;
				end else begin
					e_kind = OP_SEND;
					e_peer = rank_q + RANK_W'(1);
				end
			end
			ST_PRE2, ST_ROUND_RED: begin
				emit   = 1'b1;
				e_kind = OP_REDUCE;
				e_from = 1'b1;
			end
			ST_ROUND_SR: begin
				emit   = 1'b1;
				e_kind = OP_SENDRECV;
				e_peer = remote;
				e_into = 1'b1;
			end
			ST_POST: begin
				emit = 1'b1;
				if (rank_q[0]) begin
					e_kind = OP_SEND;
					e_peer = rank_q - RANK_W'(1);
				end else begin
					e_kind = OP_RECV;
					e_peer = rank_q + RANK_W'(1);
					e_from = 1'b1;
					e_into = 1'b1;
				end
			end
			ST_REL: begin
				emit   = 1'b1;
				e_kind = OP_RELEASE;
				e_from = 1'b1;
				e_into = 1'b1;
				e_last = 1'b1;
			end
			ST_ONE: begin
				emit   = 1'b1;
				e_kind = OP_COMPLETE;
				e_last = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					size_q <= size_sat;
					rank_q <= my_rank_q;
					tag_q  <= request_tag;
					long_q <= long_buffer;
					adj_q  <= SIZE_W'(1);
				end
			end
			ST_LOG: begin
				if (adj_dbl <= {1'b0, size_q})
					adj_q <= adj_dbl[SIZE_W-1:0];
			end
			ST_EXTRA: extra_q <= RANK_W'(size_q - adj_q);
			ST_FOLD: begin
				folded_q  <= fold_now;
				newrank_q <= fold_now ? (rank_q >> 1) : (rank_q - extra_q);
				dist_q    <= SIZE_W'(1);
			end
			ST_ROUND_RED: begin
				if (slot_free)
					dist_q <= dist_dbl;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (slot_free)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			kind_q <= e_kind;
			peer_q <= e_peer;
			from_q <= e_from;
			into_q <= e_into;
			last_q <= e_last;
			tag_out  <= tag_q;
			long_out <= long_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign op_kind      = kind_q;
	assign peer         = peer_q;
	assign from_receive = from_q;
	assign into_receive = into_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	// a group of one ends with its only operation
	a_complete_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == OP_COMPLETE |-> last_q)
		else $error("complete-at-once operation without last");

	// the log search never overshoots the group size
	a_adj_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOG |-> adj_q <= size_q)
		else $error("power-of-two size above group size");

	// every round runs at a distance below the power-of-two size
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND_SR |-> dist_q < adj_q)
		else $error("round distance out of range");

	// an accepted request always starts the sequencer
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("request accepted but sequencer idle");
`endif

endmodule
`default_nettype wire
